// ===== src/kpar_pkg.sv =====
// kpar_pkg: shared types, codes and priority tables of the keypad press and auto-repeat block
package kpar_pkg;

	localparam int KEY_COUNT = 10;
	localparam int CODE_W    = 4;
	localparam int CNT_W     = 8;
	localparam int PRESS_LEN = 10;
	localparam int RPT_LEN   = 4;

	typedef logic [KEY_COUNT-1:0] keys_t;
	typedef logic [CODE_W-1:0]    code_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// item kind codes
	typedef enum logic {
		KIND_SCAN = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	// configuration register indexes
	typedef enum logic {
		REG_HOLDOFF = 1'b0,
		REG_REPEAT  = 1'b1
	} cfg_reg_t;

	localparam code_t CODE_NONE = 4'd0;

	// new-press priority, highest first: K8 K1 K2 K7 K6 K5 K4 K3 K10 K9
	localparam code_t PRESS_ORDER [PRESS_LEN] = '{
		4'd8, 4'd1, 4'd2, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd10, 4'd9
	};

	// auto-repeat priority, highest first: K8 K9 K6 K5
	localparam code_t RPT_ORDER [RPT_LEN] = '{4'd8, 4'd9, 4'd6, 4'd5};

	// next state of the scanner, handed from the decode logic to the registers
	typedef struct packed {
		keys_t prev_pressed;
		cnt_t  holdoff_cnt;
		cnt_t  rpt_cnt;
		code_t code;
	} kpar_next_t;

	// first key of the press order found in a key set
	function automatic code_t pick_press(keys_t keys);
		code_t c;
		c = CODE_NONE;
		for (int i = PRESS_LEN - 1; i >= 0; i--) begin
			if (keys[4'(PRESS_ORDER[i] - 4'd1)]) begin
				c = PRESS_ORDER[i];
			end
		end
		return c;
	endfunction

	// first key of the repeat order found in a key set
	function automatic code_t pick_repeat(keys_t keys);
		code_t c;
		c = CODE_NONE;
		for (int i = RPT_LEN - 1; i >= 0; i--) begin
			if (keys[4'(RPT_ORDER[i] - 4'd1)]) begin
				c = RPT_ORDER[i];
			end
		end
		return c;
	endfunction

endpackage

// ===== src/kpar_decode.sv =====
// kpar_decode: edge detection, priority encoding and counter update for one item
module kpar_decode
	import kpar_pkg::*;
(
	input  logic       is_tick,
	input  keys_t      key_lines,
	input  keys_t      prev_pressed,
	input  cnt_t       holdoff_cnt,
	input  cnt_t       rpt_cnt,
	input  cnt_t       holdoff_ticks,
	input  cnt_t       repeat_ticks,
	output kpar_next_t nxt
);

	keys_t now_pressed;
	keys_t fresh;

	assign now_pressed = ~key_lines;
	assign fresh       = now_pressed & ~prev_pressed;

	// next state and key code
	always_comb begin
		nxt.prev_pressed = prev_pressed;
		nxt.holdoff_cnt  = holdoff_cnt;
		nxt.rpt_cnt      = rpt_cnt;
		nxt.code         = CODE_NONE;
		if (is_tick) begin
			// counters count down and stop at zero
			if (holdoff_cnt != '0) begin
				nxt.holdoff_cnt = holdoff_cnt - cnt_t'(1);
			end
			if (rpt_cnt != '0) begin
				nxt.rpt_cnt = rpt_cnt - cnt_t'(1);
			end
		end else begin
			nxt.prev_pressed = now_pressed;
			if (fresh != '0) begin
				nxt.holdoff_cnt = holdoff_ticks;
				nxt.code        = pick_press(fresh);
			end else if ((now_pressed & prev_pressed) != '0) begin
				// held key: repeat once both counters have run out
				if (holdoff_cnt == '0 && rpt_cnt == '0) begin
					nxt.code    = pick_repeat(now_pressed);
					nxt.rpt_cnt = repeat_ticks;
				end
			end
		end
	end

endmodule

// ===== src/keypad_press_and_autorepeat.sv =====
// keypad_press_and_autorepeat: top level with input stage, scanner state and result register
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------
//  input     | in_valid / in_ready    | kind, key_lines
//  result    | out_valid / out_ready  | key_code
//  config    | cfg_we (no wait)       | cfg_index, cfg_data
//
// One item per cycle while no scan waits on the result side; a scan's key code shows once it has
// passed the input register, then the result register. A tick yields no result.
// The result register parts the sides: a stall on the result side holds one scan
// in the input register; ticks keep flowing while the result register is busy until a scan is held.
// Reset clears control state, the key history and both counters, and loads
// the register defaults (hold-off 25, repeat 5).
module keypad_press_and_autorepeat
	import kpar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [9:0]  key_lines,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  key_code,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam cnt_t HOLDOFF_RESET = 8'd25;
	localparam cnt_t REPEAT_RESET  = 8'd5;

	logic       valid_s1;
	logic       kind_s1;
	keys_t      lines_s1;
	logic       adv_s1;
	logic       out_free;

	keys_t      prev_pressed_q;
	cnt_t       holdoff_cnt_q;
	cnt_t       rpt_cnt_q;
	cnt_t       holdoff_ticks_q;
	cnt_t       repeat_ticks_q;
	logic       out_valid_q;
	code_t      key_code_q;

	kpar_next_t nxt;

	// stage advance: ticks always, scans when the result register can take them
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (kind_s1 == KIND_TICK || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_ticks_q <= HOLDOFF_RESET;
			repeat_ticks_q  <= REPEAT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HOLDOFF: holdoff_ticks_q <= cfg_data;
				REG_REPEAT:  repeat_ticks_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind;
			lines_s1 <= key_lines;
		end
	end

	kpar_decode u_decode (
		.is_tick       (kind_s1 == KIND_TICK),
		.key_lines     (lines_s1),
		.prev_pressed  (prev_pressed_q),
		.holdoff_cnt   (holdoff_cnt_q),
		.rpt_cnt       (rpt_cnt_q),
		.holdoff_ticks (holdoff_ticks_q),
		.repeat_ticks  (repeat_ticks_q),
		.nxt           (nxt)
	);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q <= '0;
			holdoff_cnt_q  <= '0;
			rpt_cnt_q      <= '0;
		end else if (adv_s1) begin
			prev_pressed_q <= nxt.prev_pressed;
			holdoff_cnt_q  <= nxt.holdoff_cnt;
			rpt_cnt_q      <= nxt.rpt_cnt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && kind_s1 == KIND_SCAN;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && kind_s1 == KIND_SCAN) begin
			key_code_q <= nxt.code;
		end
	end

	assign out_valid = out_valid_q;
	assign key_code  = key_code_q;

endmodule

// ===== src/kpar_checker.sv =====
// kpar_checker: port-level assertions for the keypad block and its bind
module kpar_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] key_code
);

	// a reported code names a real key or none
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_code <= 4'd10)
		else $error("key code out of range");

	// a stalled result holds its code
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_code))
		else $error("stalled result changed");

	// a fresh result comes from an input transaction that passed through the input register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an input transaction");

	// with the result side free, the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result side empty");

endmodule

bind keypad_press_and_autorepeat kpar_checker u_kpar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.key_code  (key_code)
);
